>>> hdl/cit_pkg.sv
// Package for the circular interpolation table: widths, opcodes, status codes,
// register indexes and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
package cit_pkg;
  localparam int unsigned BinsDefault   = 64;
  localparam int unsigned StepsDefault  = 16;
  localparam int unsigned AngW          = 15;
  localparam int unsigned NoiseW        = 16;
  localparam int unsigned Circle        = 23040;
  localparam int unsigned FineCircle    = 360 * 16384;
  localparam int unsigned FineW         = 24;

  localparam logic [1:0] OpClear  = 2'd0;
  localparam logic [1:0] OpInsert = 2'd1;
  localparam logic [1:0] OpEval   = 2'd2;
  localparam logic [1:0] OpNone   = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  localparam logic [1:0] RegOwnX = 2'd0;
  localparam logic [1:0] RegOwnY = 2'd1;
  localparam logic [1:0] RegTgtX = 2'd2;
  localparam logic [1:0] RegTgtY = 2'd3;

  // atan(2^-i) in 1/16384 degree
  function automatic logic [FineW-1:0] atan_fine(input logic [5:0] i);
    logic [FineW-1:0] r;
    begin
      case (i)
        6'd0: r = 24'd737280;  6'd1: r = 24'd435242;  6'd2: r = 24'd229970;
        6'd3: r = 24'd116736;  6'd4: r = 24'd58595;   6'd5: r = 24'd29326;
        6'd6: r = 24'd14667;   6'd7: r = 24'd7334;    6'd8: r = 24'd3667;
        6'd9: r = 24'd1833;    6'd10: r = 24'd917;    6'd11: r = 24'd458;
        6'd12: r = 24'd229;    6'd13: r = 24'd115;    6'd14: r = 24'd57;
        6'd15: r = 24'd29;     6'd16: r = 24'd14;     6'd17: r = 24'd7;
        6'd18: r = 24'd4;      6'd19: r = 24'd2;      6'd20: r = 24'd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction
endpackage

>>> hdl/cit_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module cit_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> hdl/cit_divider.sv
// Restoring divider, one quotient bit per cycle, for the interpolation.
// Unsigned magnitude in, quotient rounded half up (numerator carries den/2).
`timescale 1ns / 1ps
module cit_divider #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, done_q;
  logic [DenW:0]   trial;

  always_comb begin
    trial  = {rem_q[DenW-1:0], quot_q[NumW-1]};
    quot_d = {quot_q[NumW-2:0], 1'b0};
    rem_d  = trial;
    if (trial >= {1'b0, den_q}) begin
      rem_d     = trial - {1'b0, den_q};
      quot_d[0] = 1'b1;
    end
    cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_d;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

>>> hdl/cit_regs.sv
// APB register file holding own ship and target positions.
// Depends on cit_pkg for register indexes.
`timescale 1ns / 1ps
module cit_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic signed [31:0] own_x_o,
  output logic signed [31:0] own_y_o,
  output logic signed [31:0] tgt_x_o,
  output logic signed [31:0] tgt_y_o
);
  import cit_pkg::*;
  logic [31:0] reg_q [4];
  logic [1:0]  idx;
  logic        wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'b00) ? reg_q[idx] : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) reg_q[k] <= '0;
    end else if (wr && paddr[1:0] == 2'b00) begin
      reg_q[idx] <= pwdata;
    end
  end

  assign own_x_o = reg_q[RegOwnX];
  assign own_y_o = reg_q[RegOwnY];
  assign tgt_x_o = reg_q[RegTgtX];
  assign tgt_y_o = reg_q[RegTgtY];
endmodule

>>> hdl/circular_interp_table.sv
// Top level of the circular interpolation table: sequencer, bin RAMs,
// CORDIC datapath and divider. Depends on cit_pkg, cit_ram, cit_divider, cit_regs.
`timescale 1ns / 1ps
// A word is taken when start_i is high and busy_o low; its result word
// appears for a single cycle with done_o and cannot be held off, and the
// next word can be taken in that same cycle. Clear and the unused opcode
// go straight to S_OUT, which gives their result. Insert scans the table
// entry by entry through the single RAM port and then shifts the tail up
// one entry at a time; a bearing already held only has its noise rewritten,
// and a new bearing on a full table gives StFull. On a non-empty table
// Evaluate runs CORDIC_STEPS iterations of the iterative add/shift unit,
// scans for the bracketing bins, then runs the 34-bit divider; an empty
// table gives StEmpty. A bearing that hits a bin exactly skips the divider.
module circular_interp_table #(
  parameter int unsigned BINS         = cit_pkg::BinsDefault,
  parameter int unsigned CORDIC_STEPS = cit_pkg::StepsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [14:0] angle_i,
  input  logic signed [15:0] noise_level_i,
  output logic        done_o,
  output logic signed [15:0] utility_o,
  output logic [6:0]  bin_count_o,
  output logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cit_pkg::*;
  localparam int unsigned AW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int unsigned CW = $clog2(BINS + 1);
  localparam int unsigned SW = $clog2(CORDIC_STEPS + 1);
  localparam int unsigned NumW = 34;

  typedef enum logic [4:0] {
    S_IDLE, S_ISCAN, S_ISCANW, S_SHRD, S_SHWR, S_IWR,
    S_CSUB, S_CINIT, S_CITER, S_CFIN, S_MIR,
    S_ESCAN, S_ESCANW, S_ERD0, S_ERD0W, S_ERDL, S_ERDLW, S_MUL, S_DSTART, S_DIV,
    S_OUT
  } state_e;

  state_e state_q;
  logic signed [31:0] own_x, own_y, tgt_x, tgt_y;

  cit_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .own_x_o(own_x), .own_y_o(own_y), .tgt_x_o(tgt_x), .tgt_y_o(tgt_y)
  );

  logic [14:0] ang_q;
  logic signed [15:0] noise_q;
  logic [CW-1:0] used_q, idx_q, pos_q;
  logic [AW-1:0] addr;
  logic          we;
  logic [14:0]   wbear, rbear;
  logic [15:0]   wnoise, rnoise;
  logic signed [15:0] utility_q;
  logic [1:0]    status_q;
  logic          done_q;

  cit_ram #(.Width(AngW), .Depth(BINS)) u_bear (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wbear), .rdata_o(rbear));
  cit_ram #(.Width(NoiseW), .Depth(BINS)) u_noise (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wnoise), .rdata_o(rnoise));

  // CORDIC registers
  logic signed [35:0] cx_q, cy_q;
  logic signed [FineW+1:0] cz_q;
  logic [SW-1:0] step_q;
  logic signed [32:0] dx_q, dy_q;
  logic [14:0] tb_q;
  logic [15:0] b_q;
  logic signed [35:0] xs, ys;
  logic [5:0] sh;
  logic signed [FineW+1:0] h;
  logic [FineW+1:0] hr;
  logic [16:0] mir_v;
  logic [15:0] mir_b;

  assign sh = 6'(step_q);
  assign xs = cx_q >>> sh;
  assign ys = cy_q >>> sh;

  // interpolation operands
  logic [14:0] lo_b;
  logic [15:0] hi_b;
  logic signed [15:0] lo_n, hi_n;
  logic [15:0] span, wa, wb;
  logic signed [33:0] acc_q;
  logic signed [32:0] prod;
  logic        mul_ph_q, acc_neg;
  logic [15:0] den_q;
  logic        div_start;
  logic        div_done;
  logic [NumW-1:0] div_num, quot;

  assign prod = $signed({1'b0, mul_ph_q ? wb : wa}) *
                (mul_ph_q ? hi_n : lo_n);
  assign div_num = acc_neg ? NumW'(-acc_q) + NumW'(den_q >> 1)
                           : NumW'(acc_q) + NumW'(den_q >> 1);

  cit_divider #(.NumW(NumW), .DenW(16)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(den_q),
    .done_o(div_done), .quot_o(quot));

  logic signed [16:0] res;
  always_comb begin
    res = acc_neg ? 17'(quot) : -17'(quot);
  end

  logic [15:0] b_plus;
  always_comb begin
    addr   = AW'(idx_q);
    we     = 1'b0;
    wbear  = rbear;
    wnoise = rnoise;
    div_start = 1'b0;
    case (state_q)
      S_SHWR: begin
        we = 1'b1;
      end
      S_IWR: begin
        we = 1'b1; wbear = ang_q; wnoise = noise_q;
      end
      S_SHRD: addr = AW'(idx_q - CW'(1));
      S_ERDL: addr = AW'(used_q - CW'(1));
      S_ERD0: addr = '0;
      S_DSTART: div_start = 1'b1;
      default: ;
    endcase
    b_plus = b_q + 16'(Circle);
    span = hi_b - 16'(lo_b);
    wa = hi_b - b_q;
    wb = b_q - 16'(lo_b);
    h = cz_q;
    if (h >= $signed((FineW+2)'(FineCircle))) h = h - (FineW+2)'(FineCircle);
    if (h < 0) h = h + (FineW+2)'(FineCircle);
    hr = (FineW+2)'(h + 128) >> 8;
    // 2*tb - course, folded into 0..23039
    mir_v = {1'b0, tb_q, 1'b0} + 17'(Circle) - {2'b0, ang_q};
    if (mir_v >= 17'(2 * Circle)) mir_b = 16'(mir_v - 17'(2 * Circle));
    else if (mir_v >= 17'(Circle)) mir_b = 16'(mir_v - 17'(Circle));
    else mir_b = 16'(mir_v);
  end

  logic        wrapmode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      done_q    <= 1'b0;
      utility_q <= '0;
      status_q  <= StOk;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            ang_q   <= (angle_i >= 15'(Circle)) ? angle_i - 15'(Circle) : angle_i;
            noise_q <= noise_level_i;
            idx_q   <= '0;
            status_q  <= StOk;
            utility_q <= '0;
            case (opcode_i)
              OpClear: begin used_q <= '0; state_q <= S_OUT; end
              OpInsert: state_q <= S_ISCAN;
              OpEval: state_q <= (used_q == '0) ? S_OUT : S_CSUB;
              default: state_q <= S_OUT;
            endcase
            if (opcode_i == OpEval && used_q == '0) status_q <= StEmpty;
          end
        end
        S_ISCAN: begin
          if (idx_q == used_q) begin
            if (used_q == CW'(BINS)) begin
              status_q <= StFull; state_q <= S_OUT;
            end else begin
              pos_q <= used_q; state_q <= S_SHRD;
            end
          end else state_q <= S_ISCANW;
        end
        S_ISCANW: begin
          if (rbear == ang_q) begin
            state_q <= S_IWR;
          end else if (ang_q < rbear) begin
            if (used_q == CW'(BINS)) begin
              status_q <= StFull; state_q <= S_OUT;
            end else begin
              pos_q <= idx_q;
              idx_q <= used_q; state_q <= S_SHRD;
            end
          end else begin
            idx_q <= idx_q + CW'(1); state_q <= S_ISCAN;
          end
        end
        // shift from the top down to the insert point held in pos_q
        S_SHRD: begin
          if (idx_q == pos_q) begin
            used_q <= used_q + CW'(1); state_q <= S_IWR;
          end else state_q <= S_SHWR;
        end
        S_SHWR: begin
          idx_q <= idx_q - CW'(1); state_q <= S_SHRD;
        end
        S_IWR: state_q <= S_OUT;
        S_CSUB: begin
          dx_q <= 33'(tgt_x) - 33'(own_x);
          dy_q <= 33'(tgt_y) - 33'(own_y);
          state_q <= S_CINIT;
        end
        S_CINIT: begin
          step_q <= '0;
          if (dx_q == 0 && dy_q == 0) begin
            tb_q <= 15'd5760; state_q <= S_MIR;
          end else begin
            if (dy_q < 0) begin
              cx_q <= -36'(dy_q); cy_q <= -36'(dx_q); cz_q <= 26'(180 * 16384);
            end else begin
              cx_q <= 36'(dy_q); cy_q <= 36'(dx_q); cz_q <= '0;
            end
            state_q <= S_CITER;
          end
        end
        S_CITER: begin
          if (cy_q >= 0) begin
            cx_q <= cx_q + ys; cy_q <= cy_q - xs;
            cz_q <= cz_q + $signed({2'b0, atan_fine(sh)});
          end else begin
            cx_q <= cx_q - ys; cy_q <= cy_q + xs;
            cz_q <= cz_q - $signed({2'b0, atan_fine(sh)});
          end
          step_q <= step_q + SW'(1);
          if (step_q == SW'(CORDIC_STEPS - 1)) state_q <= S_CFIN;
        end
        S_CFIN: begin
          tb_q <= (hr >= 26'(Circle)) ? 15'(hr - 26'(Circle)) : 15'(hr);
          state_q <= S_MIR;
        end
        S_MIR: begin
          b_q <= mir_b;
          idx_q <= '0;
          state_q <= S_ESCAN;
        end
        S_ESCAN: begin
          if (idx_q == used_q) state_q <= S_ERDL;
          else state_q <= S_ESCANW;
        end
        S_ESCANW: begin
          if ({1'b0, rbear} == b_q) begin
            utility_q <= (rnoise == 16'h8000) ? 16'sh7fff : -$signed(rnoise);
            state_q <= S_OUT;
          end else if (b_q < {1'b0, rbear}) begin
            if (idx_q == '0) state_q <= S_ERDL;
            else begin
              hi_b <= {1'b0, rbear}; hi_n <= rnoise; idx_q <= idx_q - CW'(1);
              wrapmode_q <= 1'b0; state_q <= S_ERD0;
            end
          end else begin
            lo_b <= rbear; lo_n <= rnoise;
            idx_q <= idx_q + CW'(1); state_q <= S_ESCAN;
          end
        end
        S_ERD0: state_q <= S_ERD0W;
        S_ERD0W: begin
          if (wrapmode_q) begin
            hi_b <= 16'(rbear) + 16'(Circle); hi_n <= rnoise;
            if (b_q < 16'(lo_b)) b_q <= b_plus;
          end
          mul_ph_q <= 1'b0; acc_q <= '0; state_q <= S_MUL;
        end
        S_ERDL: state_q <= S_ERDLW;
        S_ERDLW: begin
          lo_b <= rbear; lo_n <= rnoise; wrapmode_q <= 1'b1;
          state_q <= S_ERD0;
        end
        S_MUL: begin
          acc_q <= acc_q + 34'(prod);
          if (!mul_ph_q) begin
            mul_ph_q <= 1'b1;
            den_q <= span;
          end else state_q <= S_DSTART;
        end
        S_DSTART: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            if (res > 17'sd32767) utility_q <= 16'sh7fff;
            else if (res < -17'sd32768) utility_q <= 16'sh8000;
            else utility_q <= 16'(res);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          done_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // neg when accumulated numerator below zero
  always_comb acc_neg = acc_q[33];

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign utility_o   = utility_q;
  assign bin_count_o = 7'(used_q);
  assign status_o    = status_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("done outside idle");
  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(BINS)) else $error("bin count overflow");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted word dropped");
endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for circular_interp_table: drives command words and
// APB register writes, and checks each result word against a built-in predictor.
// Depends on cit_pkg and the circular_interp_table RTL.
`timescale 1ns / 1ps
module tb_top;
  import cit_pkg::*;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic signed [15:0] utility;
    logic [6:0]         bin_count;
    logic [1:0]         status;
  } result_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  opcode_i = OpClear;
  logic [14:0] angle_i = '0;
  logic signed [15:0] noise_level_i = '0;
  logic        done_o;
  logic signed [15:0] utility_o;
  logic [6:0]  bin_count_o;
  logic [1:0]  status_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  circular_interp_table i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .angle_i, .noise_level_i,
    .done_o, .utility_o, .bin_count_o, .status_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor state
  longint      pos_reg [4];
  int unsigned bearing_tab [TableDepth];
  int          noise_tab [TableDepth];
  int unsigned bins_held;

  result_word_t pending_results[$];
  int unsigned  error_count = 0;
  int unsigned  words_sent = 0;
  int unsigned  words_checked = 0;
  int unsigned  idle_pct = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  full_drops = 0;
  int unsigned  empty_evals = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // compass bearing from own ship to target, in 1/64 degree
  function automatic longint sight_bearing();
    longint dx, dy, x, y, z, base, xs, ys, h, r;
    begin
      dx = pos_reg[RegTgtX] - pos_reg[RegOwnX];
      dy = pos_reg[RegTgtY] - pos_reg[RegOwnY];
      if (dx == 0 && dy == 0) return 5760;
      x = dy;
      y = dx;
      z = 0;
      base = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        base = 180 * 16384;
      end
      for (int i = 0; i < StepsDefault; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z += longint'(atan_fine(6'(i)));
        end else begin
          x = x - ys;
          y = y + xs;
          z -= longint'(atan_fine(6'(i)));
        end
      end
      h = (base + z) % longint'(FineCircle);
      if (h < 0) h += FineCircle;
      r = (h + 128) >> 8;
      if (r >= Circle) r -= Circle;
      return r;
    end
  endfunction

  function automatic longint round_div(longint num, longint den);
    begin
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
    end
  endfunction

  function automatic longint noise_at(longint b);
    longint lo, hi, t;
    begin
      for (int i = 0; i < bins_held; i++)
        if (b == bearing_tab[i]) return noise_tab[i];
      for (int i = 0; i + 1 < bins_held; i++) begin
        lo = bearing_tab[i];
        hi = bearing_tab[i+1];
        if (b > lo && b < hi)
          return round_div(longint'(noise_tab[i]) * (hi - b) +
                           longint'(noise_tab[i+1]) * (b - lo), hi - lo);
      end
      // wrap through 360 degrees from the last bin to the first
      lo = bearing_tab[bins_held-1];
      hi = longint'(bearing_tab[0]) + Circle;
      t = (b >= lo) ? b : b + Circle;
      return round_div(longint'(noise_tab[bins_held-1]) * (hi - t) +
                       longint'(noise_tab[0]) * (t - lo), hi - lo);
    end
  endfunction

  function automatic logic [1:0] store_bin(int unsigned a, int nz);
    int unsigned pos;
    begin
      pos = bins_held;
      for (int i = 0; i < bins_held; i++) begin
        if (a == bearing_tab[i]) begin
          noise_tab[i] = nz;
          return StOk;
        end
        if (a < bearing_tab[i]) begin
          pos = i;
          break;
        end
      end
      if (bins_held >= TableDepth) return StFull;
      for (int j = bins_held; j > pos; j--) begin
        bearing_tab[j] = bearing_tab[j-1];
        noise_tab[j] = noise_tab[j-1];
      end
      bearing_tab[pos] = a;
      noise_tab[pos] = nz;
      bins_held++;
      return StOk;
    end
  endfunction

  function automatic result_word_t table_step(logic [1:0] op, logic [14:0] ang,
                                              logic signed [15:0] nz);
    result_word_t res;
    int unsigned a;
    longint util, b;
    begin
      a = int'(ang) % Circle;
      util = 0;
      res.status = StOk;
      case (op)
        OpClear: bins_held = 0;
        OpInsert: res.status = store_bin(a, int'(nz));
        OpEval: begin
          if (bins_held == 0) begin
            res.status = StEmpty;
          end else begin
            b = (2 * sight_bearing() + 2 * Circle - a) % Circle;
            util = -noise_at(b);
            if (util > 32767) util = 32767;
            if (util < -32768) util = -32768;
          end
        end
        default: ;
      endcase
      res.utility = 16'(util);
      res.bin_count = 7'(bins_held);
      return res;
    end
  endfunction

  // send one command word; start stays high until the next gap
  task automatic send_word(logic [1:0] op, logic [14:0] ang, logic signed [15:0] nz);
    result_word_t res;
    begin
      if ($urandom_range(99) < idle_pct) begin
        // hold off while the block is ready
        start_i <= 1'b0;
        @(posedge clk_i iff !busy_o);
        repeat ($urandom_range(4, 1)) @(posedge clk_i);
      end
      start_i <= 1'b1;
      opcode_i <= op;
      angle_i <= ang;
      noise_level_i <= nz;
      @(posedge clk_i iff !busy_o);
      res = table_step(op, ang, nz);
      if (op == OpInsert && res.status == StFull) full_drops++;
      if (op == OpEval && res.status == StEmpty) empty_evals++;
      pending_results.insert(pending_results.size(), res);
      words_sent++;
    end
  endtask

  task automatic wait_idle();
    begin
      start_i <= 1'b0;
      @(posedge clk_i);
      while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
      repeat (8) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i iff pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      pos_reg[idx] = longint'(signed'(val));
      @(posedge clk_i);
    end
  endtask

  task automatic set_positions(logic [31:0] ox, logic [31:0] oy,
                               logic [31:0] tx, logic [31:0] ty);
    begin
      wait_idle();
      write_reg(RegOwnX, ox);
      write_reg(RegOwnY, oy);
      write_reg(RegTgtX, tx);
      write_reg(RegTgtY, ty);
    end
  endtask

  function automatic logic [14:0] rand_angle();
    begin
      case ($urandom_range(9))
        0: return 15'h7fff - 15'($urandom_range(9727));
        1: return 15'($urandom_range(3)) ? 15'd23039 : 15'd0;
        2: return (bins_held != 0) ? 15'(bearing_tab[$urandom_range(bins_held-1)]) : 15'd0;
        default: return 15'($urandom_range(23039));
      endcase
    end
  endfunction

  // mostly insert and evaluate, rare clear and unused opcode
  task automatic run_random(int unsigned n);
    int unsigned pick;
    logic [1:0] op;
    begin
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(99);
        if (pick < 2) op = OpClear;
        else if (pick < 4) op = OpNone;
        else if (pick < 50) op = OpInsert;
        else op = OpEval;
        send_word(op, rand_angle(), 16'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    begin
      send_word(OpEval, 15'd100, 16'sd0);
      send_word(OpInsert, 15'd0, -16'sd32768);
      send_word(OpEval, 15'd0, 16'sd0);
      send_word(OpEval, 15'h7fff, 16'sd0);
      send_word(OpInsert, 15'd23039, 16'sd32767);
      send_word(OpInsert, 15'h7fff, 16'sd1000);
      send_word(OpInsert, 15'd11520, -16'sd3);
      send_word(OpInsert, 15'd11520, 16'sd7);
      send_word(OpEval, 15'd11520, 16'sd0);
      send_word(OpEval, 15'd0, 16'sd0);
      send_word(OpEval, 15'd23039, 16'sd0);
      send_word(OpEval, 15'd9727, 16'sd0);
      send_word(OpEval, 15'd5000, 16'sd0);
      send_word(OpEval, 15'd23040, 16'sd0);
      send_word(OpNone, 15'h7fff, -16'sd1);
      send_word(OpClear, 15'd0, 16'sd0);
      send_word(OpEval, 15'd0, 16'sd0);
    end
  endtask

  task automatic test_full_table();
    begin
      send_word(OpClear, 15'd0, 16'sd0);
      for (int k = 0; k < TableDepth; k++)
        send_word(OpInsert, 15'(k * 359 + 7), 16'($urandom));
      send_word(OpInsert, 15'd3, 16'sd55);
      send_word(OpInsert, 15'd366, -16'sd55);
      send_word(OpEval, 15'd1, 16'sd0);
      send_word(OpEval, 15'd23039, 16'sd0);
    end
  endtask

  task automatic test_positions();
    begin
      set_positions(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      run_random(120);
      set_positions(32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0);
      run_random(120);
      set_positions(32'd50, 32'h7fff_ffff, 32'd50, 32'h8000_0000);
      run_random(120);
      set_positions(32'h0, 32'h0, 32'h0, 32'h0);
      run_random(60);
    end
  endtask

  task automatic test_random_traffic();
    begin
      for (int p = 0; p < 6; p++) begin
        set_positions($urandom, $urandom, $urandom, $urandom);
        run_random(31);
        set_positions(32'($signed(16'($urandom))), 32'($signed(16'($urandom))),
                      32'($signed(16'($urandom))), 32'($signed(16'($urandom))));
        run_random(31);
      end
    end
  endtask

  always @(posedge clk_i) begin
    result_word_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result word with no command pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (utility_o !== want.utility) begin
          $error("utility: expected %0d, got %0d", want.utility, utility_o);
          error_count++;
        end
        if (bin_count_o !== want.bin_count) begin
          $error("bin_count: expected %0d, got %0d", want.bin_count, bin_count_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
      end
    end
  end

  // watchdog: count cycles without any handshake
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("timeout: %0d results still pending", pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < 4; r++) pos_reg[r] = 0;
    bins_held = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 22;
    test_directed();
    test_full_table();
    test_positions();
    idle_pct = 63;
    test_random_traffic();
    idle_pct = 0;
    test_random_traffic();
    wait_idle();
    repeat (300) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    $display("sent %0d command words, checked %0d results over several positions",
             words_sent, words_checked);
    $display("full-table drops %0d, empty-table evaluations %0d", full_drops, empty_evals);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> circular_interp_table.f
hdl/cit_pkg.sv
hdl/cit_ram.sv
hdl/cit_divider.sv
hdl/cit_regs.sv
hdl/circular_interp_table.sv
tb/sv/tb_top.sv
